/* rtl/fud_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fud_pkg - form-urlencoded decoder shared definitions
// Word types, character codes, result kinds and the hex digit decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_RESULTS = 4;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] decoded_byte;
		logic       last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} entry_t;

	typedef struct packed {
		entry_t [MAX_RESULTS-1:0] ent;
		logic   [2:0]             cnt;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/fud_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fud_front - decoder front end
// Classifies each accepted byte against the pair state and builds the
// bundle of up to four results that it causes.
// ----------------------------------------------------------------------------
module fud_front
	import fud_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_word_t word,
	output logic          push,
	output bundle_t       bundle
);

	logic       in_value_part_q, pair_started_q;
	logic [1:0] pending_count_q;
	logic [7:0] pending_digit_q;

	logic       iv_d, ps_d, done;
	logic [1:0] pc_d, k;
	logic [7:0] pd_d, b;
	logic [2:0] n;
	logic [4:0] hb, hp;
	bundle_t    bun;

	always_comb begin
		bun  = '0;
		n    = 3'd0;
		iv_d = in_value_part_q;
		ps_d = pair_started_q;
		pc_d = pending_count_q;
		pd_d = pending_digit_q;
		done = 1'b0;
		b    = word.data_byte;
		k    = in_value_part_q ? KIND_VALUE : KIND_NAME;
		hb   = hex_nib(b);
		hp   = hex_nib(pending_digit_q);
		if (b == CH_AMP) begin
			if (pending_count_q != 2'd0) begin
				bun.ent[n[1:0]] = '{k, CH_PERCENT};
				n = n + 3'd1;
			end
			if (pending_count_q == 2'd2) begin
				bun.ent[n[1:0]] = '{k, pending_digit_q};
				n = n + 3'd1;
			end
			if (pair_started_q) begin
				bun.ent[n[1:0]] = '{KIND_END, 8'd0};
				n = n + 3'd1;
			end
			iv_d = 1'b0;
			ps_d = 1'b0;
			pc_d = 2'd0;
			pd_d = 8'd0;
		end else begin
			ps_d = 1'b1;
			if (pending_count_q == 2'd1) begin
				if (hb[4]) begin
					pd_d = b;
					pc_d = 2'd2;
					done = 1'b1;
				end else begin
					bun.ent[n[1:0]] = '{k, CH_PERCENT};
					n = n + 3'd1;
					pc_d = 2'd0;
					pd_d = 8'd0;
				end
			end else if (pending_count_q == 2'd2) begin
				if (hb[4]) begin
					bun.ent[n[1:0]] = '{k, {hp[3:0], hb[3:0]}};
					n = n + 3'd1;
					done = 1'b1;
				end else begin
					bun.ent[n[1:0]] = '{k, CH_PERCENT};
					n = n + 3'd1;
					bun.ent[n[1:0]] = '{k, pending_digit_q};
					n = n + 3'd1;
				end
				pc_d = 2'd0;
				pd_d = 8'd0;
			end
			if (!done) begin
				if (b == CH_PERCENT) begin
					pc_d = 2'd1;
					pd_d = 8'd0;
				end else if (b == CH_EQUAL && !in_value_part_q) begin
					iv_d = 1'b1;
				end else if (b == CH_PLUS) begin
					bun.ent[n[1:0]] = '{k, CH_SPACE};
					n = n + 3'd1;
				end else begin
					bun.ent[n[1:0]] = '{k, b};
					n = n + 3'd1;
				end
			end
		end
		if (word.end_of_string) begin
			if (pc_d != 2'd0) begin
				bun.ent[n[1:0]] = '{k, CH_PERCENT};
				n = n + 3'd1;
			end
			if (pc_d == 2'd2) begin
				bun.ent[n[1:0]] = '{k, pd_d};
				n = n + 3'd1;
			end
			if (ps_d) begin
				bun.ent[n[1:0]] = '{KIND_END, 8'd0};
				n = n + 3'd1;
			end
			iv_d = 1'b0;
			ps_d = 1'b0;
			pc_d = 2'd0;
			pd_d = 8'd0;
		end
		bun.cnt = n;
	end

	assign push   = accept && (n != 3'd0);
	assign bundle = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_part_q <= 1'b0;
			pair_started_q  <= 1'b0;
			pending_count_q <= 2'd0;
			pending_digit_q <= 8'd0;
		end else if (accept) begin
			in_value_part_q <= iv_d;
			pair_started_q  <= ps_d;
			pending_count_q <= pc_d;
			pending_digit_q <= pd_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/fud_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fud_queue - result bundle queue
// Short register queue that decouples the front end from the serialiser.
// ----------------------------------------------------------------------------
module fud_queue
	import fud_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
)
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	input  wire logic    pop,
	output bundle_t      head,
	output q_stat_t      stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= advance(wr_ptr_q);
			if (pop)
				rd_ptr_q <= advance(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

/* rtl/fud_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fud_back - result serialiser
// Walks the head bundle one result a cycle into the output register while it
// is empty or being taken, and marks the last result of each bundle.
// ----------------------------------------------------------------------------
module fud_back
	import fud_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t head,
	input  wire q_stat_t stat,
	output logic         pop,
	output logic         dst_valid,
	input  wire logic    dst_ready,
	output out_word_t    dst_word
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_word_q;
	logic       load, last;
	entry_t     cur;

	assign cur  = head.ent[idx_q];
	assign load = !stat.empty && (!out_valid_q || dst_ready);
	assign last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop  = load && last;

	assign dst_valid = out_valid_q;
	assign dst_word  = out_word_q;

	always_ff @(posedge clk) begin
		if (load)
			out_word_q <= '{cur.kind, cur.value, last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (dst_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* rtl/form_urlencoded_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_core - form-urlencoded string decoder
// Decodes a form-encoded byte stream into name bytes, value bytes and
// end-of-pair markers.
// ----------------------------------------------------------------------------
// A byte is taken every cycle while the bundle queue (QUEUE_DEPTH entries)
// has room. Each byte yields zero to four results, delivered one per cycle
// through a registered output while the receiver is ready; the queue absorbs
// short bursts of escape flushes and pair ends. A result passes through the
// bundle queue and then the output register before it is valid on the output.
// No start-up sweep.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_core
	import fud_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_ready,
	input  wire in_word_t src_word,
	output logic          dst_valid,
	input  wire logic     dst_ready,
	output out_word_t     dst_word
);

	logic    accept, push, pop;
	bundle_t bundle, head;
	q_stat_t stat;

	assign src_ready = !stat.full;
	assign accept    = src_valid && src_ready;

	fud_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.word   (src_word),
		.push   (push),
		.bundle (bundle)
	);

	fud_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	fud_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_word  (dst_word)
	);

endmodule
`default_nettype wire

/* rtl/fud_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fud_checker - port checks for the decoder core
// Watches the decoder ports; bound to the top level.
// ----------------------------------------------------------------------------
module fud_checker
	import fud_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      src_valid,
	input wire logic      src_ready,
	input wire in_word_t  src_word,
	input wire logic      dst_valid,
	input wire logic      dst_ready,
	input wire out_word_t dst_word
);

	a_src_known: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid |-> !$isunknown({src_ready, src_word}))
		else $error("unknown source word or ready");

	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_word))
		else $error("output word changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> dst_word.kind != 2'd3)
		else $error("illegal result kind");

	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.kind == KIND_END |->
			dst_word.decoded_byte == 8'd0 && dst_word.last_of_run)
		else $error("end of pair not last or carries data");

endmodule

bind form_urlencoded_decoder_core fud_checker u_fud_checker (.*);
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - form-urlencoded decoder core
// Drives encoded strings, directed then random, through the source channel
// with bursty idling, and checks every decoded word from the result channel
// against an in-bench decoder while the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module testbench
	import fud_pkg::*;
();

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	in_word_t  src_word;
	logic      dst_valid;
	logic      dst_ready;
	out_word_t dst_word;

	form_urlencoded_decoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_word (src_word),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_word (dst_word)
	);

	in_word_t   encoded_bytes[$];
	out_word_t  decoded_due[$];
	out_word_t  run_words[$];
	logic [7:0] text[$];
	int         fail_count;

	logic       in_value;
	logic       pair_open;
	logic [1:0] held_cnt;
	logic [7:0] held_digit;

	logic       src_took;
	int         burst_left;
	int         gap_left;
	logic [15:0] stall_pattern;
	int         pattern_age;

	// ------------------------------------------------------------------
	// decoder prediction
	// ------------------------------------------------------------------
	function automatic logic is_hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "a")
			v = c - "a" + 8'd10;
		else if (c >= "A")
			v = c - "A" + 8'd10;
		else
			v = c - "0";
		return v[3:0];
	endfunction

	function automatic logic [1:0] part_kind();
		return in_value ? KIND_VALUE : KIND_NAME;
	endfunction

	function automatic void put_result(input logic [1:0] kind, input logic [7:0] value);
		out_word_t w;
		w.kind         = kind;
		w.decoded_byte = (kind == KIND_END) ? 8'h00 : value;
		w.last_of_run  = 1'b0;
		run_words = {run_words, w};
	endfunction

	function automatic void flush_held();
		if (held_cnt >= 2'd1)
			put_result(part_kind(), CH_PERCENT);
		if (held_cnt >= 2'd2)
			put_result(part_kind(), held_digit);
		held_cnt   = 2'd0;
		held_digit = 8'h00;
	endfunction

	function automatic void clear_pair();
		in_value   = 1'b0;
		pair_open  = 1'b0;
		held_cnt   = 2'd0;
		held_digit = 8'h00;
	endfunction

	function automatic void decode_byte(input in_word_t w);
		logic [7:0] b;
		logic       done;
		out_word_t  r;
		b    = w.data_byte;
		done = 1'b0;
		run_words.delete();
		if (b == CH_AMP) begin
			flush_held();
			if (pair_open)
				put_result(KIND_END, 8'h00);
			clear_pair();
		end else begin
			pair_open = 1'b1;
			if (held_cnt == 2'd1) begin
				if (is_hex_char(b)) begin
					held_digit = b;
					held_cnt   = 2'd2;
					done       = 1'b1;
				end else begin
					flush_held();
				end
			end else if (held_cnt == 2'd2) begin
				if (is_hex_char(b)) begin
					put_result(part_kind(), {digit_value(held_digit), digit_value(b)});
					held_cnt   = 2'd0;
					held_digit = 8'h00;
					done       = 1'b1;
				end else begin
					flush_held();
				end
			end
			if (!done) begin
				if (b == CH_PERCENT) begin
					held_cnt   = 2'd1;
					held_digit = 8'h00;
				end else if (b == CH_EQUAL && !in_value) begin
					in_value = 1'b1;
				end else if (b == CH_PLUS) begin
					put_result(part_kind(), CH_SPACE);
				end else begin
					put_result(part_kind(), b);
				end
			end
		end
		if (w.end_of_string) begin
			flush_held();
			if (pair_open)
				put_result(KIND_END, 8'h00);
			clear_pair();
		end
		for (int i = 0; i < run_words.size(); i++) begin
			r             = run_words[i];
			r.last_of_run = (i == run_words.size() - 1);
			decoded_due = {decoded_due, r};
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic void push_word(input logic [7:0] b, input logic eos);
		in_word_t w;
		w.data_byte     = b;
		w.end_of_string = eos;
		encoded_bytes = {encoded_bytes, w};
	endfunction

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], i == s.len() - 1);
	endfunction

	function automatic logic [7:0] hex_pick();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] plain_pick();
		logic [7:0] c;
		c = 8'($urandom_range(8'h21, 8'h7E));
		if (is_hex_char(c) || c == CH_PERCENT || c == CH_AMP || c == CH_EQUAL || c == CH_PLUS)
			c = "x";
		return c;
	endfunction

	function automatic void add_char(input logic [7:0] c);
		text = {text, c};
	endfunction

	function automatic void add_token();
		case ($urandom_range(0, 9))
			0: add_char(CH_PLUS);
			1, 2: begin
				add_char(CH_PERCENT);
				add_char(hex_pick());
				add_char(hex_pick());
			end
			3: begin
				add_char(CH_PERCENT);
				add_char(hex_pick());
				add_char(plain_pick());
			end
			4: begin
				add_char(CH_PERCENT);
				add_char(plain_pick());
			end
			5: add_char(CH_EQUAL);
			6: add_char(8'($urandom_range(0, 255)));
			7: add_char(hex_pick());
			default: add_char(plain_pick());
		endcase
	endfunction

	function automatic void add_random_string();
		int n;
		int pairs;
		text.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				add_char(8'($urandom_range(0, 255)));
		end else begin
			pairs = $urandom_range(1, 3);
			for (int p = 0; p < pairs; p++) begin
				if (p > 0)
					add_char(CH_AMP);
				if ($urandom_range(0, 7) == 0)
					add_char(CH_AMP);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					add_token();
				if ($urandom_range(0, 4) != 0) begin
					add_char(CH_EQUAL);
					n = $urandom_range(0, 5);
					for (int i = 0; i < n; i++)
						add_token();
				end
			end
			if ($urandom_range(0, 7) == 0)
				add_char(CH_AMP);
		end
		if (text.size() == 0)
			add_char(CH_EQUAL);
		for (int i = 0; i < text.size(); i++)
			push_word(text[i], i == text.size() - 1);
	endfunction

	// ------------------------------------------------------------------
	// clock, reset and sequencing
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n     = 1'b0;
		fail_count = 0;
		clear_pair();

		queue_text("%41=+%z");
		queue_text("&&x&");
		queue_text("=");
		queue_text("%4=%");
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b0);
		queue_text("%4g");
		while (encoded_bytes.size() < 500)
			add_random_string();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (encoded_bytes.size() != 0 || src_valid || decoded_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// source driver
	// ------------------------------------------------------------------
	initial begin
		src_valid  = 1'b0;
		src_word   = '0;
		dst_ready  = 1'b0;
		burst_left = 0;
		gap_left   = 0;
		stall_pattern = 16'hFFFF;
		pattern_age   = 0;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!(src_valid && !src_took)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				src_valid <= 1'b0;
			end else if (encoded_bytes.size() > 0) begin
				src_word  <= encoded_bytes.pop_front();
				src_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stalls
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic [15:0] next_pattern;
		if (arst_n) begin
			next_pattern = {stall_pattern[0], stall_pattern[15:1]};
			if (pattern_age >= 48) begin
				case ($urandom_range(0, 3))
					0: next_pattern = 16'hFFFF;
					1: next_pattern = 16'($urandom) | 16'h0001;
					2: next_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
					default: next_pattern = 16'h0001;
				endcase
				pattern_age <= 0;
			end else begin
				pattern_age <= pattern_age + 1;
			end
			dst_ready     <= stall_pattern[0];
			stall_pattern <= next_pattern;
		end
	end

	// ------------------------------------------------------------------
	// monitor and checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_word_t exp_w;
		if (!arst_n) begin
			src_took <= 1'b0;
		end else begin
			src_took <= src_valid && src_ready;
			if (src_valid && src_ready)
				decode_byte(src_word);
			if (dst_valid && dst_ready) begin
				if (decoded_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, got kind %0d byte %02h last %0b",
						$time, dst_word.kind, dst_word.decoded_byte, dst_word.last_of_run);
					fail_count++;
				end else begin
					exp_w = decoded_due.pop_front();
					if (dst_word.kind !== exp_w.kind) begin
						$display("%0t: kind mismatch, expected %0d, got %0d",
							$time, exp_w.kind, dst_word.kind);
						fail_count++;
					end
					if (dst_word.decoded_byte !== exp_w.decoded_byte) begin
						$display("%0t: decoded_byte mismatch, expected %02h, got %02h",
							$time, exp_w.decoded_byte, dst_word.decoded_byte);
						fail_count++;
					end
					if (dst_word.last_of_run !== exp_w.last_of_run) begin
						$display("%0t: last_of_run mismatch, expected %0b, got %0b",
							$time, exp_w.last_of_run, dst_word.last_of_run);
						fail_count++;
					end
				end
			end
		end
	end

endmodule
